/* rtl/brb_pkg.sv */
// Shared types and constants for the byte ring buffer.
// No dependencies; used by every other file of the block except brb_ram.
package brb_pkg;

	localparam int OP_W    = 3;
	localparam int DATA_W  = 8;
	localparam int COUNT_W = 7;
	localparam int LEVEL_W = 10;

	localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
	localparam logic [OP_W-1:0] OP_READ  = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
	localparam logic [OP_W-1:0] OP_SKIP  = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

	typedef enum logic {
		ST_IDLE,
		ST_BURST
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;      // command transfer this cycle
		logic load_single; // load the one-and-only result of the command
		logic issue;       // issue a store read for the next burst byte
		logic load_burst;  // move the store read data into the output register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic burst;   // current command is a read or peek with a nonzero grant
		logic rem_one; // one burst byte left to issue
	} dp_status_t;

endpackage

/* rtl/brb_cmd_if.sv */
// Command channel of the byte ring buffer: valid/ready plus the command fields.
// Depends on brb_pkg.
interface brb_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [brb_pkg::OP_W-1:0]     op;
	logic [brb_pkg::DATA_W-1:0]   data_in;
	logic [brb_pkg::COUNT_W-1:0]  count;

	modport source (output valid, op, data_in, count, input ready);
	modport sink   (input valid, op, data_in, count, output ready);
endinterface

/* rtl/brb_res_if.sv */
// Result channel of the byte ring buffer: valid/ready plus the result fields.
// Depends on brb_pkg.
interface brb_res_if;
	logic                         valid;
	logic                         ready;
	logic [brb_pkg::DATA_W-1:0]   data_out;
	logic                         last;
	logic [brb_pkg::COUNT_W-1:0]  granted;
	logic [brb_pkg::LEVEL_W-1:0]  fill_level;
	logic [brb_pkg::LEVEL_W-1:0]  free_level;

	modport source (output valid, data_out, last, granted, fill_level, free_level, input ready);
	modport sink   (input valid, data_out, last, granted, fill_level, free_level, output ready);
endinterface

/* rtl/brb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/brb_ctrl.sv */
// Controller of the byte ring buffer: command acceptance, burst sequencing,
// read-in-flight and output-register valid flags. Depends on brb_pkg.
module brb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	output logic                res_valid,
	input  logic                res_ready,
	input  brb_pkg::dp_status_t status,
	output brb_pkg::ctrl_cmd_t  ctrl
);

	brb_pkg::state_t state_q;
	brb_pkg::state_t state_d;
	logic            s1_valid_q;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || res_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			brb_pkg::ST_IDLE: begin
				if (ctrl.accept && status.burst) state_d = brb_pkg::ST_BURST;
			end
			brb_pkg::ST_BURST: begin
				if (ctrl.issue && status.rem_one) state_d = brb_pkg::ST_IDLE;
			end
			default: state_d = brb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = 1'b0;
		ctrl      = '0;
		case (state_q)
			brb_pkg::ST_IDLE: begin
				// wait until the last burst byte has left the read stage
				cmd_ready        = out_free && !s1_valid_q;
				ctrl.accept      = cmd_valid && cmd_ready;
				ctrl.load_single = ctrl.accept && !status.burst;
			end
			brb_pkg::ST_BURST: begin
				ctrl.issue = !s1_valid_q || out_free;
			end
			default: ;
		endcase
		ctrl.load_burst = s1_valid_q && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= brb_pkg::ST_IDLE;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.issue) begin
				s1_valid_q <= 1'b1;
			end else if (ctrl.load_burst) begin
				s1_valid_q <= 1'b0;
			end
			if (ctrl.load_single || ctrl.load_burst) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;

	a_no_cmd_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == brb_pkg::ST_BURST |-> !cmd_ready)
		else $error("command taken during a burst");

	a_inflight_held: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !out_free |=> s1_valid_q)
		else $error("store read dropped while output stalled");

	a_burst_ends: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.issue && status.rem_one |=> state_q == brb_pkg::ST_IDLE)
		else $error("burst did not end after final issue");

endmodule

/* rtl/brb_dp.sv */
// Datapath of the byte ring buffer: head/tail/fill registers, clamping,
// byte store, burst read pointer and output register. Depends on brb_pkg, brb_ram.
module brb_dp #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [brb_pkg::OP_W-1:0]      op,
	input  logic [brb_pkg::DATA_W-1:0]    data_in,
	input  logic [brb_pkg::COUNT_W-1:0]   count,
	input  brb_pkg::ctrl_cmd_t            ctrl,
	output brb_pkg::dp_status_t           status,
	output logic [brb_pkg::DATA_W-1:0]    data_out,
	output logic                          last,
	output logic [brb_pkg::COUNT_W-1:0]   granted,
	output logic [brb_pkg::LEVEL_W-1:0]   fill_level,
	output logic [brb_pkg::LEVEL_W-1:0]   free_level
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = (PW > brb_pkg::COUNT_W) ? PW : brb_pkg::COUNT_W;
	localparam int FW = (PW > brb_pkg::LEVEL_W) ? PW : brb_pkg::LEVEL_W;
	localparam logic [PW:0]                  DEPTH_W   = (PW+1)'(DEPTH);
	localparam logic [PW-1:0]                FULL_LVL  = PW'(DEPTH - 1);
	localparam logic [brb_pkg::COUNT_W-1:0]  BURST_MAX = brb_pkg::COUNT_W'(MAX_BURST);

	logic [PW-1:0]                 head_q;
	logic [PW-1:0]                 tail_q;
	logic [PW-1:0]                 fill_q;
	logic [PW-1:0]                 rd_ptr_q;
	logic [brb_pkg::COUNT_W-1:0]   rem_q;
	logic [brb_pkg::COUNT_W-1:0]   burst_granted_q;
	logic                          last_s1;

	logic [brb_pkg::DATA_W-1:0]    data_q;
	logic                          last_q;
	logic [brb_pkg::COUNT_W-1:0]   granted_q;
	logic [PW-1:0]                 fill_out_q;

	logic [brb_pkg::COUNT_W-1:0]   req;
	logic [CW-1:0]                 n_ext;
	logic [brb_pkg::COUNT_W-1:0]   n;
	logic [PW-1:0]                 n_pw;
	logic                          is_full;
	logic                          is_wr;
	logic [PW-1:0]                 fill_nxt;
	logic [brb_pkg::COUNT_W-1:0]   g_single;
	logic [brb_pkg::DATA_W-1:0]    ram_rdata;
	logic [FW-1:0]                 fill_ext;
	logic [FW-1:0]                 free_ext;
	logic [PW:0]                   fill_chk;

	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [PW-1:0] d);
		logic [PW:0] s;
		s = {1'b0, p} + {1'b0, d};
		if (s >= DEPTH_W) s = s - DEPTH_W;
		return s[PW-1:0];
	endfunction

	// clamp to the burst limit, then to the fill level
	assign req   = (count > BURST_MAX) ? BURST_MAX : count;
	assign n_ext = (CW'(req) > CW'(fill_q)) ? CW'(fill_q) : CW'(req);
	assign n     = n_ext[brb_pkg::COUNT_W-1:0];
	assign n_pw  = n_ext[PW-1:0];

	assign is_full = (fill_q == FULL_LVL);
	assign is_wr   = (op == brb_pkg::OP_WRITE);

	assign status.burst   = ((op == brb_pkg::OP_READ) || (op == brb_pkg::OP_PEEK))
		&& (n != '0);
	assign status.rem_one = (rem_q == brb_pkg::COUNT_W'(1));

	always_comb begin
		fill_nxt = fill_q;
		g_single = '0;
		case (op)
			brb_pkg::OP_WRITE: begin
				if (!is_full) begin
					fill_nxt = fill_q + PW'(1);
					g_single = brb_pkg::COUNT_W'(1);
				end
			end
			brb_pkg::OP_READ, brb_pkg::OP_SKIP: begin
				fill_nxt = fill_q - n_pw;
				g_single = n;
			end
			brb_pkg::OP_PEEK: g_single = n;
			brb_pkg::OP_CLEAR: fill_nxt = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			rem_q  <= '0;
		end else begin
			if (ctrl.accept) begin
				fill_q <= fill_nxt;
				rem_q  <= n;
				case (op)
					brb_pkg::OP_WRITE: begin
						if (!is_full) tail_q <= wrap_add(tail_q, PW'(1));
					end
					brb_pkg::OP_READ, brb_pkg::OP_SKIP: head_q <= wrap_add(head_q, n_pw);
					brb_pkg::OP_CLEAR: begin
						head_q <= '0;
						tail_q <= '0;
					end
					default: ;
				endcase
			end else if (ctrl.issue) begin
				rem_q <= rem_q - brb_pkg::COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			rd_ptr_q        <= head_q;
			burst_granted_q <= n;
		end else if (ctrl.issue) begin
			rd_ptr_q <= wrap_add(rd_ptr_q, PW'(1));
		end
		if (ctrl.issue) begin
			last_s1 <= status.rem_one;
		end
		if (ctrl.load_single) begin
			data_q     <= '0;
			last_q     <= 1'b1;
			granted_q  <= g_single;
			fill_out_q <= fill_nxt;
		end else if (ctrl.load_burst) begin
			data_q     <= ram_rdata;
			last_q     <= last_s1;
			granted_q  <= burst_granted_q;
			fill_out_q <= fill_q;
		end
	end

	brb_ram #(
		.WIDTH (brb_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ctrl.accept && is_wr && !is_full),
		.waddr (tail_q),
		.wdata (data_in),
		.re    (ctrl.issue),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	assign fill_ext   = FW'(fill_out_q);
	assign free_ext   = FW'(FULL_LVL - fill_out_q);
	assign data_out   = data_q;
	assign last       = last_q;
	assign granted    = granted_q;
	assign fill_level = fill_ext[brb_pkg::LEVEL_W-1:0];
	assign free_level = free_ext[brb_pkg::LEVEL_W-1:0];

	assign fill_chk = (tail_q >= head_q) ? ({1'b0, tail_q} - {1'b0, head_q})
		: ({1'b0, tail_q} + DEPTH_W - {1'b0, head_q});

	a_fill_matches_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		fill_chk == {1'b0, fill_q})
		else $error("fill count out of step with head/tail");

	a_issue_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.issue |-> rem_q != '0)
		else $error("store read issued with no bytes left");

	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.issue && status.rem_one |=> last_s1)
		else $error("final burst byte not marked last");

endmodule

/* rtl/byte_ring_buffer.sv */
// Byte ring buffer: a circular byte queue of DEPTH slots holding at most DEPTH-1
// bytes, with write, read, peek, skip and clear commands. Depends on brb_pkg,
// brb_cmd_if, brb_res_if, brb_ctrl, brb_dp.
//
// Write, skip, clear, unknown opcodes and read/peek with nothing granted give one
// result each. A read or peek granting n bytes gives n results at one per cycle
// while the result channel is not stalled, out of the byte store's single registered
// read port; the next command is taken once the last byte has reached the output
// register. Requests are clamped to MAX_BURST and then to the fill level. The
// store needs no clearing after reset. Fill and free levels are reported in 10 bits.
module byte_ring_buffer #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 64
) (
	input logic       clk,
	input logic       arst_n,
	brb_cmd_if.sink   cmd,
	brb_res_if.source res
);

	brb_pkg::ctrl_cmd_t  ctrl;
	brb_pkg::dp_status_t status;

	brb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.status    (status),
		.ctrl      (ctrl)
	);

	brb_dp #(
		.DEPTH     (DEPTH),
		.MAX_BURST (MAX_BURST)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (cmd.op),
		.data_in    (cmd.data_in),
		.count      (cmd.count),
		.ctrl       (ctrl),
		.status     (status),
		.data_out   (res.data_out),
		.last       (res.last),
		.granted    (res.granted),
		.fill_level (res.fill_level),
		.free_level (res.free_level)
	);

endmodule
